[design/edd_pkg.sv]
// shared types and constants for the event deque with dedupe
package edd_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int ID_W          = 32;
    localparam int DATA_W        = 32;
    localparam int CAP_W         = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_GET   = 2'd1;
    localparam logic [1:0] MODE_CHECK = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam int OPT_SKIP_DUP = 0;
    localparam int OPT_FRONT    = 1;

    typedef struct packed {
        logic [1:0]        mode;
        logic [ID_W-1:0]   evt_id;
        logic [DATA_W-1:0] payload;
        logic [1:0]        add_options;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   out_event_id;
        logic [DATA_W-1:0] out_payload;
        logic              found;
        logic              dropped_duplicate;
        logic [CAP_W-1:0]  free_space;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_EXEC
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOOK,
        CELL_PUSH_FRONT,
        CELL_PUSH_BACK,
        CELL_POP
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [ID_W-1:0]   evt_id;
        logic [DATA_W-1:0] payload;
    } cell_ctrl_t;

endpackage

[design/edd_cell.sv]
// one queue slot: holds an entry, shifts with its neighbors, compares against the key
module edd_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  edd_pkg::cell_ctrl_t         ctrl,
    input  logic [CW-1:0]               count,
    input  logic [edd_pkg::ID_W-1:0]    prev_id,
    input  logic [edd_pkg::DATA_W-1:0]  prev_payload,
    input  logic [edd_pkg::ID_W-1:0]    next_id,
    input  logic [edd_pkg::DATA_W-1:0]  next_payload,
    output logic [edd_pkg::ID_W-1:0]    id,
    output logic [edd_pkg::DATA_W-1:0]  payload,
    output logic                        match
);

    localparam logic [CW-1:0] POS = CW'(IDX);

    logic [edd_pkg::ID_W-1:0]   id_reg;
    logic [edd_pkg::ID_W-1:0]   id_next;
    logic [edd_pkg::DATA_W-1:0] payload_reg;
    logic [edd_pkg::DATA_W-1:0] payload_next;
    logic                       match_reg;
    logic                       match_next;
    logic                       occupied;

    assign occupied = (POS < count);

    always_comb
    begin
        id_next      = id_reg;
        payload_next = payload_reg;
        match_next   = match_reg;
        case (ctrl.op)
            edd_pkg::CELL_LOOK:
            begin
                match_next = occupied && (id_reg == ctrl.evt_id);
            end
            edd_pkg::CELL_PUSH_FRONT:
            begin
                id_next      = prev_id;
                payload_next = prev_payload;
            end
            edd_pkg::CELL_PUSH_BACK:
            begin
                if (POS == count)
                begin
                    id_next      = ctrl.evt_id;
                    payload_next = ctrl.payload;
                end
            end
            edd_pkg::CELL_POP:
            begin
                id_next      = next_id;
                payload_next = next_payload;
            end
            default:
            begin
                id_next = id_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        id_reg      <= id_next;
        payload_reg <= payload_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign id      = id_reg;
    assign payload = payload_reg;
    assign match   = match_reg;

endmodule

[design/event_deque_with_dedupe.sv]
// top level: bounded event queue with push to front and duplicate suppression
//
// channel  direction  handshake              payload
// req      in         req_valid / req_stall  edd_pkg::req_t
// rsp      out        rsp_valid / rsp_stall  edd_pkg::rsp_t
// cfg      in         cfg_we                 cfg_wdata (capacity)
//
// each request passes through accept, id compare in every cell, then execute
// the compare cycle is set by the match flags registered inside the cells
// one request is in flight at a time; the next is accepted while a result waits
// a stalled result holds the execute step, so at most one result is ever pending
// reset clears the count and sets capacity to sixteen; entry storage needs no clearing pass
module event_deque_with_dedupe #(
    parameter int DEPTH = edd_pkg::DEPTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  edd_pkg::req_t                 req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output edd_pkg::rsp_t                 rsp,
    input  logic                          cfg_we,
    input  logic [edd_pkg::CAP_W-1:0]     cfg_wdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > edd_pkg::CAP_W) ? CW : edd_pkg::CAP_W;
    localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

    edd_pkg::state_t            state_reg;
    edd_pkg::state_t            state_next;
    edd_pkg::req_t              req_reg;
    logic [edd_pkg::CAP_W-1:0]  capacity_reg;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    edd_pkg::rsp_t              rsp_reg;
    edd_pkg::rsp_t              rsp_next;
    logic                       rsp_valid_reg;
    logic                       rsp_valid_next;

    logic                       accept;
    logic                       look_en;
    logic                       exec_go;
    logic                       hit;
    logic                       full;
    logic [XW-1:0]              cap_x;
    logic [XW-1:0]              cap_act;
    logic [XW-1:0]              count_next_x;
    edd_pkg::cell_op_t          exec_op;
    edd_pkg::cell_ctrl_t        ctrl;

    logic [edd_pkg::ID_W-1:0]   cell_id      [DEPTH];
    logic [edd_pkg::DATA_W-1:0] cell_payload [DEPTH];
    logic [DEPTH-1:0]           cell_match;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            edd_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = edd_pkg::ST_LOOK;
                end
            end
            edd_pkg::ST_LOOK:
            begin
                state_next = edd_pkg::ST_EXEC;
            end
            edd_pkg::ST_EXEC:
            begin
                if (!(rsp_valid_reg && rsp_stall))
                begin
                    state_next = edd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = edd_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        req_stall = 1'b1;
        look_en   = 1'b0;
        exec_go   = 1'b0;
        case (state_reg)
            edd_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            edd_pkg::ST_LOOK:
            begin
                look_en = 1'b1;
            end
            edd_pkg::ST_EXEC:
            begin
                exec_go = !(rsp_valid_reg && rsp_stall);
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign accept = req_valid && !req_stall;

    // active capacity: zero acts as one, limited to the built depth
    assign cap_x   = XW'(capacity_reg);
    assign cap_act = (cap_x == '0) ? XW'(1) : ((cap_x > DEPTH_X) ? DEPTH_X : cap_x);
    assign full    = (XW'(count_reg) >= cap_act);
    assign hit     = |cell_match;

    // execute step: decide the cell operation and build the result
    always_comb
    begin
        exec_op    = edd_pkg::CELL_HOLD;
        count_next = count_reg;
        rsp_next   = '0;
        case (req_reg.mode)
            edd_pkg::MODE_ADD:
            begin
                if (full)
                begin
                    rsp_next.status = edd_pkg::STATUS_FULL;
                end
                else if (req_reg.add_options[edd_pkg::OPT_SKIP_DUP] && hit)
                begin
                    rsp_next.dropped_duplicate = 1'b1;
                end
                else
                begin
                    exec_op    = req_reg.add_options[edd_pkg::OPT_FRONT]
                                 ? edd_pkg::CELL_PUSH_FRONT : edd_pkg::CELL_PUSH_BACK;
                    count_next = count_reg + CW'(1);
                end
            end
            edd_pkg::MODE_GET:
            begin
                if (count_reg == '0)
                begin
                    rsp_next.status = edd_pkg::STATUS_EMPTY;
                end
                else
                begin
                    rsp_next.out_event_id = cell_id[0];
                    rsp_next.out_payload  = cell_payload[0];
                    exec_op               = edd_pkg::CELL_POP;
                    count_next            = count_reg - CW'(1);
                end
            end
            edd_pkg::MODE_CHECK:
            begin
                rsp_next.found = hit;
            end
            default:
            begin
                rsp_next.status = edd_pkg::STATUS_OK;
            end
        endcase
        count_next_x        = XW'(count_next);
        rsp_next.free_space = (cap_act > count_next_x)
                              ? edd_pkg::CAP_W'(cap_act - count_next_x) : '0;
    end

    always_comb
    begin
        ctrl.evt_id  = req_reg.evt_id;
        ctrl.payload = req_reg.payload;
        if (look_en)
        begin
            ctrl.op = edd_pkg::CELL_LOOK;
        end
        else if (exec_go)
        begin
            ctrl.op = exec_op;
        end
        else
        begin
            ctrl.op = edd_pkg::CELL_HOLD;
        end
    end

    // row of cells, head at index zero
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [edd_pkg::ID_W-1:0]   prev_id;
        logic [edd_pkg::DATA_W-1:0] prev_payload;
        logic [edd_pkg::ID_W-1:0]   next_id;
        logic [edd_pkg::DATA_W-1:0] next_payload;

        if (g == 0)
        begin : g_head
            assign prev_id      = req_reg.evt_id;
            assign prev_payload = req_reg.payload;
        end
        else
        begin : g_mid
            assign prev_id      = cell_id[g-1];
            assign prev_payload = cell_payload[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_tail
            assign next_id      = cell_id[g];
            assign next_payload = cell_payload[g];
        end
        else
        begin : g_body
            assign next_id      = cell_id[g+1];
            assign next_payload = cell_payload[g+1];
        end

        edd_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .count        (count_reg),
            .prev_id      (prev_id),
            .prev_payload (prev_payload),
            .next_id      (next_id),
            .next_payload (next_payload),
            .id           (cell_id[g]),
            .payload      (cell_payload[g]),
            .match        (cell_match[g])
        );
    end

    always_comb
    begin
        if (exec_go)
        begin
            rsp_valid_next = 1'b1;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= edd_pkg::ST_IDLE;
            capacity_reg  <= edd_pkg::CAP_RESET;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            if (exec_go)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (exec_go)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        XW'(count_reg) <= DEPTH_X)
        else $error("entry count beyond built depth");

    a_count_only_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
        !exec_go |=> $stable(count_reg))
        else $error("entry count moved outside execute step");

    a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == edd_pkg::ST_LOOK))
        else $error("accepted request did not enter compare step");

    a_empty_get: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && (req_reg.mode == edd_pkg::MODE_GET) && (count_reg == '0))
        |=> (rsp_valid_reg && (rsp_reg.status == edd_pkg::STATUS_EMPTY)))
        else $error("get on empty queue not reported empty");

endmodule
